// ===== rtl/fcd_pkg.sv =====
// types and constants shared by the cache directory files
`default_nettype none
package fcd_pkg;

  typedef enum logic [0:0] {
    CMD_LOOKUP = 1'b0,
    CMD_FILL   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STATUS_HIT     = 3'd0,
    STATUS_MISS    = 3'd1,
    STATUS_STALE   = 3'd2,
    STATUS_STORED  = 3'd3,
    STATUS_EVICTED = 3'd4,
    STATUS_REJECT  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_CAPACITY   = 2'd0,
    CFG_LRU_MODE   = 2'd1,
    CFG_MAX_LENGTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_CHECK,
    ST_EVICT,
    ST_INSERT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] mtime;
    logic [31:0] len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [4:0]  CAP_RESET = 5'd3;
  localparam logic        LRU_RESET = 1'b0;
  localparam logic [31:0] MAXLEN_RESET = 32'd65536;

endpackage
`default_nettype wire

// ===== rtl/fcd_ifs.sv =====
// request and response channel interfaces
`default_nettype none
interface fcd_in_if import fcd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] key_id;
  logic [31:0] mod_time;
  logic [31:0] data_length;

  modport source (output valid, command, key_id, mod_time, data_length, input ready);
  modport sink   (input valid, command, key_id, mod_time, data_length, output ready);
endinterface

interface fcd_out_if import fcd_pkg::*; ();
  logic        valid;
  logic        ready;
  status_e     status;
  logic [31:0] hit_length;
  logic [31:0] evicted_key;

  modport source (output valid, status, hit_length, evicted_key, input ready);
  modport sink   (input valid, status, hit_length, evicted_key, output ready);
endinterface
`default_nettype wire

// ===== rtl/fcd_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module fcd_ram #(
  parameter int Width = 96,
  parameter int Depth = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  wire logic [Width-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic      [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/fifo_lru_cache_directory_core.sv =====
// cache directory top level: ordered entry store, scan sequencer and response register
// a lookup or fill scans every slot, one per cycle, through the entry ram read port,
//   and then loads its answer into the response register
// a rejected fill, or an eviction from an empty directory, skips the scan and goes straight to the response register
// one word at a time: no new word is accepted until the last one is in the response register
// reset: directory empty (all slots invalid, count zero), capacity 3, fifo order, max length 65536
`default_nettype none
module fifo_lru_cache_directory_core import fcd_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  fcd_in_if.sink                     in_i,
  fcd_out_if.source                  out_o
);

  // slot / rank index width and count width (count can reach MAX_ENTRIES)
  localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  // compare width for count against saturated capacity, covers MAX_ENTRIES up to 511
  localparam int XW = 9;

  // sequencer
  state_e state_q, state_d;

  // configuration registers
  logic [4:0]  cap_q;
  logic        lru_q;
  logic [31:0] maxlen_q;

  // per slot valid bits and order ranks (rank 0 is the front)
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [SW-1:0]          rank_q [MAX_ENTRIES];
  logic [SW-1:0]          rank_d [MAX_ENTRIES];
  logic [CW-1:0]          count_q, count_d;

  // scan pointer and compare stage behind the ram read
  logic [CW-1:0] ptr_q, ptr_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [SW-1:0] cmp_slot_q, cmp_slot_d;

  // captured request word
  cmd_e        cmd_q, cmd_d;
  logic [31:0] key_q, key_d;
  logic [31:0] time_q, time_d;
  logic [31:0] len_q, len_d;
  logic        evict_q, evict_d;

  // scan results
  logic          found_q, found_d;
  logic [SW-1:0] best_slot_q, best_slot_d;
  logic [SW-1:0] best_rank_q, best_rank_d;
  logic [31:0]   best_time_q, best_time_d;
  logic [31:0]   best_len_q, best_len_d;
  logic [SW-1:0] last_slot_q, last_slot_d;
  logic [31:0]   last_key_q, last_key_d;
  logic          free_found_q, free_found_d;
  logic [SW-1:0] free_slot_q, free_slot_d;

  // result being built, then the response register
  status_e     res_status_q, res_status_d;
  logic [31:0] res_len_q, res_len_d;
  logic [31:0] res_key_q, res_key_d;
  logic        out_vld_q, out_vld_d;
  status_e     out_status_q, out_status_d;
  logic [31:0] out_len_q, out_len_d;
  logic [31:0] out_key_q, out_key_d;

  // entry ram
  logic               ram_we, ram_re;
  logic [SW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             rd_entry, wr_entry;

  // helpers
  logic [XW-1:0] cap_sat;
  logic          evict_now;
  logic [SW-1:0] last_rank;
  logic [SW-1:0] ins_slot;
  logic          cmp_valid;
  logic [SW-1:0] cmp_rank;

  assign rd_entry  = entry_t'(ram_rdata);
  assign ram_wdata = ENTRY_W'(wr_entry);

  // capacity saturates at the slot count
  assign cap_sat   = (XW'(cap_q) > XW'(MAX_ENTRIES)) ? XW'(MAX_ENTRIES) : XW'(cap_q);
  assign evict_now = (XW'(count_q) + XW'(1)) > cap_sat;
  // ranks form 0..count-1, so the last entry holds rank count-1
  assign last_rank = SW'(count_q - CW'(1));
  assign cmp_valid = valid_q[cmp_slot_q];
  assign cmp_rank  = rank_q[cmp_slot_q];
  // reuse the lowest free slot; the evicted slot competes with it
  assign ins_slot  = (free_found_q && (!evict_q || (free_slot_q < last_slot_q))) ?
                     free_slot_q : last_slot_q;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_status_q;
  assign out_o.hit_length  = out_len_q;
  assign out_o.evicted_key = out_key_q;

  fcd_ram #(
    .Width(ENTRY_W),
    .Depth(MAX_ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      lru_q        <= LRU_RESET;
      maxlen_q     <= MAXLEN_RESET;
      valid_q      <= '0;
      count_q      <= '0;
      ptr_q        <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      evict_q      <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CAPACITY:   cap_q    <= cfg_data_i[4:0];
          CFG_LRU_MODE:   lru_q    <= cfg_data_i[0];
          CFG_MAX_LENGTH: maxlen_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      valid_q      <= valid_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      cmp_vld_q    <= cmp_vld_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      evict_q      <= evict_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rank_q       <= rank_d;
    cmp_slot_q   <= cmp_slot_d;
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    time_q       <= time_d;
    len_q        <= len_d;
    best_slot_q  <= best_slot_d;
    best_rank_q  <= best_rank_d;
    best_time_q  <= best_time_d;
    best_len_q   <= best_len_d;
    last_slot_q  <= last_slot_d;
    last_key_q   <= last_key_d;
    free_slot_q  <= free_slot_d;
    res_status_q <= res_status_d;
    res_len_q    <= res_len_d;
    res_key_q    <= res_key_d;
    out_status_q <= out_status_d;
    out_len_q    <= out_len_d;
    out_key_q    <= out_key_d;
  end

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    rank_d       = rank_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_slot_d   = cmp_slot_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    time_d       = time_q;
    len_d        = len_q;
    evict_d      = evict_q;
    found_d      = found_q;
    best_slot_d  = best_slot_q;
    best_rank_d  = best_rank_q;
    best_time_d  = best_time_q;
    best_len_d   = best_len_q;
    last_slot_d  = last_slot_q;
    last_key_d   = last_key_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    res_status_d = res_status_q;
    res_len_d    = res_len_q;
    res_key_d    = res_key_q;
    out_status_d = out_status_q;
    out_len_d    = out_len_q;
    out_key_d    = out_key_q;
    // response drops once taken
    out_vld_d    = out_vld_q && !out_o.ready;

    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = ptr_q[SW-1:0];
    ram_waddr      = ins_slot;
    wr_entry.key   = key_q;
    wr_entry.mtime = time_q;
    wr_entry.len   = len_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d        = cmd_e'(in_i.command);
          key_d        = in_i.key_id;
          time_d       = in_i.mod_time;
          len_d        = in_i.data_length;
          res_len_d    = '0;
          res_key_d    = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          evict_d      = 1'b0;
          ptr_d        = '0;
          cmp_vld_d    = 1'b0;
          state_d      = ST_SCAN;
          if (cmd_e'(in_i.command) == CMD_FILL) begin
            if (in_i.data_length > maxlen_q) begin
              res_status_d = STATUS_REJECT;
              state_d      = ST_RESP;
            end else if (evict_now && (count_q == '0)) begin
              // nothing to keep: the new entry is itself evicted
              res_status_d = STATUS_EVICTED;
              res_key_d    = in_i.key_id;
              state_d      = ST_RESP;
            end else begin
              evict_d = evict_now;
            end
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle
        if (ptr_q < CW'(MAX_ENTRIES)) begin
          ram_re     = 1'b1;
          ptr_d      = ptr_q + CW'(1);
          cmp_vld_d  = 1'b1;
          cmp_slot_d = ptr_q[SW-1:0];
        end else begin
          cmp_vld_d = 1'b0;
        end
        // compare the slot read last cycle
        if (cmp_vld_q) begin
          if (cmd_q == CMD_LOOKUP) begin
            // copy nearest the front wins
            if (cmp_valid && (rd_entry.key == key_q) &&
                (!found_q || (cmp_rank < best_rank_q))) begin
              found_d     = 1'b1;
              best_slot_d = cmp_slot_q;
              best_rank_d = cmp_rank;
              best_time_d = rd_entry.mtime;
              best_len_d  = rd_entry.len;
            end
          end else begin
            if (cmp_valid && (cmp_rank == last_rank)) begin
              last_slot_d = cmp_slot_q;
              last_key_d  = rd_entry.key;
            end
            if (!cmp_valid && !free_found_q) begin
              free_found_d = 1'b1;
              free_slot_d  = cmp_slot_q;
            end
          end
        end
        if ((ptr_q == CW'(MAX_ENTRIES)) && !cmp_vld_q) begin
          if (cmd_q == CMD_LOOKUP) begin
            if (!found_q) begin
              res_status_d = STATUS_MISS;
              state_d      = ST_RESP;
            end else if (lru_q) begin
              state_d = ST_MOVE;
            end else begin
              state_d = ST_CHECK;
            end
          end else if (evict_q) begin
            state_d = ST_EVICT;
          end else begin
            state_d = ST_INSERT;
          end
        end
      end

      ST_MOVE: begin
        // entries ahead of the hit slide back one place
        for (int t = 0; t < MAX_ENTRIES; t++) begin
          if (valid_q[t] && (rank_q[t] < best_rank_q)) begin
            rank_d[t] = rank_q[t] + SW'(1);
          end
        end
        rank_d[best_slot_q] = '0;
        best_rank_d         = '0;
        state_d             = ST_CHECK;
      end

      ST_CHECK: begin
        if (best_time_q < time_q) begin
          // stale: drop it and close the gap in the order
          valid_d[best_slot_q] = 1'b0;
          for (int t = 0; t < MAX_ENTRIES; t++) begin
            if (valid_q[t] && (rank_q[t] > best_rank_q)) begin
              rank_d[t] = rank_q[t] - SW'(1);
            end
          end
          count_d      = count_q - CW'(1);
          res_status_d = STATUS_STALE;
        end else begin
          res_status_d = STATUS_HIT;
          res_len_d    = best_len_q;
        end
        state_d = ST_RESP;
      end

      ST_EVICT: begin
        // the last entry has the highest rank, so no rank moves
        valid_d[last_slot_q] = 1'b0;
        count_d              = count_q - CW'(1);
        res_key_d            = last_key_q;
        state_d              = ST_INSERT;
      end

      ST_INSERT: begin
        for (int t = 0; t < MAX_ENTRIES; t++) begin
          if (valid_q[t]) begin
            rank_d[t] = rank_q[t] + SW'(1);
          end
        end
        valid_d[ins_slot] = 1'b1;
        rank_d[ins_slot]  = '0;
        ram_we            = 1'b1;
        count_d           = count_q + CW'(1);
        res_status_d      = evict_q ? STATUS_EVICTED : STATUS_STORED;
        state_d           = ST_RESP;
      end

      ST_RESP: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_len_d    = res_len_q;
          out_key_d    = res_key_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
